// ----- design/mwf_pkg.sv -----
// Package for the running median window filter.
// Holds the shared constants and the task descriptor passed from front to back.
// No dependencies.
package mwf_pkg;

  // Default sample width (signed Q16.16 at 32 bits).
  localparam int SAMPLE_WIDTH_DEFAULT = 32;

  // Number of earlier samples kept per series.
  localparam int HISTORY_DEPTH = 4;

  // Keys seen by one window: the history plus the present sample.
  localparam int NUM_KEYS = HISTORY_DEPTH + 1;

  // Entries of the task queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Series position, 0 .. HISTORY_DEPTH.
  typedef logic [2:0] pos_t;

  // Control part of one task: the key count, the window size, the flush mark
  // and the first series position to be filtered.
  typedef struct packed {
    pos_t count;
    logic half_two;
    logic last;
    pos_t q_first;
  } task_ctrl_t;

  localparam int TASK_CTRL_WIDTH = $bits(task_ctrl_t);

endpackage

// ----- design/mwf_front.sv -----
// Front part of the running median window filter: accepts samples, keeps the
// series history and issues one task per sample that yields results.
// Depends on mwf_pkg.
module mwf_front
  import mwf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [SAMPLE_WIDTH-1:0]          sample,
  input  logic                             end_of_series,
  input  logic                             queue_full,
  output logic                             task_push,
  output task_ctrl_t                       task_ctrl,
  output logic [NUM_KEYS*SAMPLE_WIDTH-1:0] task_keys
);

  logic                    window_five;
  logic [SAMPLE_WIDTH-1:0] hist [HISTORY_DEPTH];
  pos_t                    count;
  pos_t                    half;
  logic                    accept;
  logic                    has_result;

  // Window size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_five <= 1'b1;
    end else if (cfg_we) begin
      window_five <= cfg_wdata;
    end
  end

  assign in_ready   = !queue_full;
  assign accept     = in_valid && in_ready;
  assign half       = window_five ? 3'd2 : 3'd1;
  assign has_result = (count >= half);

  // A task goes out when the sample completes a window or flushes the series.
  assign task_push = accept && (end_of_series || has_result);

  always_comb begin
    task_ctrl.count    = count;
    task_ctrl.half_two = window_five;
    task_ctrl.last     = end_of_series;
    task_ctrl.q_first  = has_result ? pos_t'(count - half) : '0;
  end

  // Keys in series order: the history, then the present sample at the count.
  always_comb begin
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      task_keys[i*SAMPLE_WIDTH +: SAMPLE_WIDTH] =
        (pos_t'(i) == count) ? sample : hist[i];
    end
    task_keys[HISTORY_DEPTH*SAMPLE_WIDTH +: SAMPLE_WIDTH] = sample;
  end

  // Series history: filled up to four samples, then shifted.
  always_ff @(posedge clk) begin
    if (accept && !end_of_series) begin
      if (count < pos_t'(HISTORY_DEPTH)) begin
        hist[count[1:0]] <= sample;
      end else begin
        for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
          hist[i] <= hist[i+1];
        end
        hist[HISTORY_DEPTH-1] <= sample;
      end
    end
  end

  // Fill count, cleared by the last sample of a series.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      if (end_of_series) begin
        count <= '0;
      end else if (count < pos_t'(HISTORY_DEPTH)) begin
        count <= count + 3'd1;
      end
    end
  end

endmodule

// ----- design/mwf_task_queue.sv -----
// Short first-in first-out queue of tasks between front and back.
// Depends on mwf_pkg for its depth.
module mwf_task_queue
  import mwf_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full       = (fill == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_data  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// ----- design/mwf_back.sv -----
// Back part of the running median window filter: walks the positions of each
// task and runs a three-stage compare, rank-select and average pipeline.
// Depends on mwf_pkg.
module mwf_back
  import mwf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             task_valid,
  input  task_ctrl_t                       task_ctrl,
  input  logic [NUM_KEYS*SAMPLE_WIDTH-1:0] task_keys,
  output logic                             task_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [SAMPLE_WIDTH-1:0]          median_value,
  output logic                             final_output
);

  // Position sequencer.
  logic [1:0] off;
  pos_t       q;
  pos_t       q_last;
  pos_t       half;
  pos_t       win_lo;
  pos_t       win_hi;
  pos_t       q_plus;
  pos_t       win_len;
  logic       issue;

  // Stage 1: keys, pairwise order and window.
  logic                    s1_valid;
  logic                    s1_ready;
  logic [SAMPLE_WIDTH-1:0] s1_keys [NUM_KEYS];
  logic [NUM_KEYS-1:0]     s1_prec [NUM_KEYS];
  logic [NUM_KEYS-1:0]     s1_mask;
  pos_t                    s1_lo_rank;
  pos_t                    s1_hi_rank;
  logic                    s1_final;
  logic [SAMPLE_WIDTH-1:0] keys [NUM_KEYS];
  logic [NUM_KEYS-1:0]     prec [NUM_KEYS];
  logic [NUM_KEYS-1:0]     mask;

  // Stage 2: the two middle values.
  logic                    s2_valid;
  logic                    s2_ready;
  logic [SAMPLE_WIDTH-1:0] s2_lo;
  logic [SAMPLE_WIDTH-1:0] s2_hi;
  logic                    s2_final;
  logic [SAMPLE_WIDTH-1:0] lo_val;
  logic [SAMPLE_WIDTH-1:0] hi_val;

  // Output stage.
  logic                    o_ready;
  logic [SAMPLE_WIDTH:0]   mid_sum;

  // Ready chain, one register stage at a time.
  assign o_ready  = !out_valid || out_ready;
  assign s2_ready = !s2_valid || o_ready;
  assign s1_ready = !s1_valid || s2_ready;

  // Window bounds of the current position, clipped to the series.
  always_comb begin
    half    = task_ctrl.half_two ? 3'd2 : 3'd1;
    q       = task_ctrl.q_first + pos_t'(off);
    q_last  = task_ctrl.last ? task_ctrl.count : task_ctrl.q_first;
    q_plus  = q + half;
    win_lo  = (q >= half) ? pos_t'(q - half) : '0;
    win_hi  = (q_plus > task_ctrl.count) ? task_ctrl.count : q_plus;
    win_len = win_hi - win_lo + 3'd1;
    for (int i = 0; i < NUM_KEYS; i++) begin
      mask[i] = (pos_t'(i) >= win_lo) && (pos_t'(i) <= win_hi);
    end
  end

  assign issue    = task_valid && s1_ready;
  assign task_pop = issue && (q == q_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      off <= '0;
    end else if (task_pop) begin
      off <= '0;
    end else if (issue) begin
      off <= off + 2'd1;
    end
  end

  // Pairwise order with ties broken by series position: prec[i][j] is set
  // when key j sorts ahead of key i.
  always_comb begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      keys[i] = task_keys[i*SAMPLE_WIDTH +: SAMPLE_WIDTH];
    end
    for (int i = 0; i < NUM_KEYS; i++) begin
      prec[i] = '0;
    end
    for (int i = 0; i < NUM_KEYS; i++) begin
      for (int j = i + 1; j < NUM_KEYS; j++) begin
        prec[j][i] = ($signed(keys[i]) <= $signed(keys[j]));
        prec[i][j] = !prec[j][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_keys    <= keys;
      s1_prec    <= prec;
      s1_mask    <= mask;
      s1_lo_rank <= (win_len - 3'd1) >> 1;
      s1_hi_rank <= win_len >> 1;
      s1_final   <= task_ctrl.last && (q == task_ctrl.count);
    end
  end

  // Rank each key inside the window and pick the two middle ones.
  always_comb begin
    pos_t rank;
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      rank = pos_t'($countones(s1_prec[i] & s1_mask));
      if (s1_mask[i] && (rank == s1_lo_rank)) begin
        lo_val = s1_keys[i];
      end
      if (s1_mask[i] && (rank == s1_hi_rank)) begin
        hi_val = s1_keys[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_lo    <= lo_val;
      s2_hi    <= hi_val;
      s2_final <= s1_final;
    end
  end

  // Floor of the mean of the middle values; equal values for an odd window.
  assign mid_sum = {s2_lo[SAMPLE_WIDTH-1], s2_lo} + {s2_hi[SAMPLE_WIDTH-1], s2_hi};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_ready) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready) begin
      median_value <= mid_sum[SAMPLE_WIDTH:1];
      final_output <= s2_final;
    end
  end

  // The position offset never passes the last of three flush results.
  assert property (@(posedge clk) disable iff (rst) off <= 2'd2)
    else $error("position offset out of range");

  // The result for the last position always retires its task.
  assert property (@(posedge clk) disable iff (rst)
    issue && task_ctrl.last && (q == task_ctrl.count) |-> task_pop)
    else $error("flush task not retired at its last position");

  // The ranks picked agree with the window size.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> ($countones(s1_mask) == int'(s1_lo_rank) + int'(s1_hi_rank) + 1))
    else $error("window size and median ranks disagree");

  // A stalled output holds its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(median_value) && $stable(final_output))
    else $error("output changed while stalled");

endmodule

// ----- design/median_window_filter_unit.sv -----
// Running median window filter, top level.
// Depends on mwf_pkg, mwf_front, mwf_task_queue and mwf_back.
//
// Usage:
//   s_tdata carries a signed sample in its low SAMPLE_WIDTH bits, s_tlast
//   marks the last sample of a series. m_tdata carries the median in its low
//   SAMPLE_WIDTH bits, m_tlast marks the last result of the series.
//   cfg_wdata, written while cfg_we is high, selects the window: 0 gives three
//   samples, 1 (the reset value) five. Write it only while the block is idle.
// Path: the task of a sample that completes its window passes the task queue,
//   then the stage-1, stage-2 and output registers. Throughput: one sample
//   per cycle in a series while the queue has room. The last sample of a
//   series flushes up to three results, one per cycle from the back part's
//   position walker unless stalled; a four-entry task queue absorbs that burst.
// Reset: rst clears the series history count, the queue and the pipeline
//   valids and sets the five-sample window. No clearing pass is needed.
// Stall: while m_tready is low the output register holds; the pipeline and
//   queue keep filling, and s_tready drops only once the queue is full.
module median_window_filter_unit
  import mwf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic                                  cfg_wdata,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [8*((SAMPLE_WIDTH+7)/8)-1:0]     s_tdata,   // sample
  input  logic                                  s_tlast,   // end_of_series
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [8*((SAMPLE_WIDTH+7)/8)-1:0]     m_tdata,   // median_value
  output logic                                  m_tlast    // final_output
);

  localparam int DATA_WIDTH  = 8 * ((SAMPLE_WIDTH + 7) / 8);
  localparam int KEYS_WIDTH  = NUM_KEYS * SAMPLE_WIDTH;
  localparam int ENTRY_WIDTH = KEYS_WIDTH + TASK_CTRL_WIDTH;

  logic                    queue_full;
  logic                    task_push;
  task_ctrl_t              push_ctrl;
  logic [KEYS_WIDTH-1:0]   push_keys;
  logic                    task_pop;
  logic                    head_valid;
  logic [ENTRY_WIDTH-1:0]  head_data;
  task_ctrl_t              head_ctrl;
  logic [KEYS_WIDTH-1:0]   head_keys;
  logic [SAMPLE_WIDTH-1:0] median_value;

  // Front: history and task issue.
  mwf_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .sample        (s_tdata[SAMPLE_WIDTH-1:0]),
    .end_of_series (s_tlast),
    .queue_full    (queue_full),
    .task_push     (task_push),
    .task_ctrl     (push_ctrl),
    .task_keys     (push_keys)
  );

  // Task queue between the two parts.
  mwf_task_queue #(
    .WIDTH (ENTRY_WIDTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (task_push),
    .push_data  ({push_keys, push_ctrl}),
    .full       (queue_full),
    .pop        (task_pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign head_ctrl = head_data[TASK_CTRL_WIDTH-1:0];
  assign head_keys = head_data[ENTRY_WIDTH-1:TASK_CTRL_WIDTH];

  // Back: median pipeline and output register.
  mwf_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .task_valid   (head_valid),
    .task_ctrl    (head_ctrl),
    .task_keys    (head_keys),
    .task_pop     (task_pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .median_value (median_value),
    .final_output (m_tlast)
  );

  assign m_tdata = DATA_WIDTH'(median_value);

endmodule

// ----- tb/sv/median_window_filter_unit_tb.sv -----
// Self-checking testbench for the running median window filter.
// Depends on mwf_pkg and median_window_filter_unit and, through it, the other design files.
// A directed table runs first, then random series with both window sizes.
module median_window_filter_unit_tb
  import mwf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEFAULT;
  localparam int DATA_WIDTH    = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int RESET_CYCLES  = 7;
  localparam int DRAIN_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS  = 234;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int NUM_DIRECTED  = 29;

  localparam logic [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

  // One expected filter output.
  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] med;
    logic                    fin;
  } filt_result_t;

  // A directed row either sends a sample or selects the window size.
  typedef enum logic {
    ROW_SAMPLE,
    ROW_WINDOW
  } row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [SAMPLE_WIDTH-1:0] data;
    logic                    eos;
    logic                    typed;
    logic [SAMPLE_WIDTH-1:0] t_med;
    logic                    t_fin;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic                  cfg_wdata = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [DATA_WIDTH-1:0] s_tdata = '0;   // sample
  logic                  s_tlast = 1'b0; // end_of_series
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [DATA_WIDTH-1:0] m_tdata;        // median_value
  logic                  m_tlast;        // final_output

  // Predictor state: earlier samples of the open series and the window size.
  logic signed [SAMPLE_WIDTH-1:0] series_hist[$];
  logic                           window_five_sel;
  filt_result_t                   pending_results[$];

  filt_result_t want_result;
  int           fail_count = 0;
  int           cycle_count = 0;
  int           ready_hold = 0;
  logic         steady_flow = 1'b0;

  // Extremes, single-sample and short series, and window changes inside a series.
  stim_row_t directed_rows [0:NUM_DIRECTED-1] = '{
    '{ROW_SAMPLE, SMP_MAX,      1'b1, 1'b1, SMP_MAX, 1'b1},
    '{ROW_SAMPLE, SMP_MIN,      1'b1, 1'b1, SMP_MIN, 1'b1},
    '{ROW_SAMPLE, SMP_MAX,      1'b0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, SMP_MIN,      1'b1, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, 32'h00030000, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, 32'hFFFE0000, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, 32'h00010000, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, SMP_MAX,      1'b0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, SMP_MIN,      1'b1, 1'b0, '0, 1'b0},
    '{ROW_WINDOW, 32'h00000000, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, 32'h00000005, 1'b1, 1'b1, 32'h00000005, 1'b1},
    '{ROW_SAMPLE, 32'hFFFFFFFF, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, 32'h00000000, 1'b1, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, SMP_MAX,      1'b0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, 32'h7FFFFFFE, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, SMP_MIN,      1'b0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, 32'h80000001, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, 32'hAAAAAAAA, 1'b1, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, 32'h00020000, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, 32'h00040000, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_WINDOW, 32'h00000001, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, 32'h00060000, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, 32'h00080000, 1'b1, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, 32'h00000001, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, 32'h00000002, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, 32'h00000003, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, 32'h00000004, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_WINDOW, 32'h00000000, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, 32'h00000005, 1'b1, 1'b0, '0, 1'b0}
  };

  median_window_filter_unit #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Median of keys[lo..hi]; an even count gives the floor of the middle pair's mean.
  function automatic logic [SAMPLE_WIDTH-1:0] window_median(
    input logic signed [SAMPLE_WIDTH-1:0] keys[NUM_KEYS], input int lo, input int hi);
    logic signed [SAMPLE_WIDTH-1:0] srt[NUM_KEYS];
    logic signed [SAMPLE_WIDTH-1:0] tmp;
    logic signed [SAMPLE_WIDTH:0]   pair_sum;
    int m;
    m = 0;
    for (int i = lo; i <= hi; i++) begin
      srt[m] = keys[i];
      m++;
    end
    for (int i = 0; i < m - 1; i++) begin
      for (int j = 0; j < m - 1 - i; j++) begin
        if (srt[j] > srt[j + 1]) begin
          tmp = srt[j];
          srt[j] = srt[j + 1];
          srt[j + 1] = tmp;
        end
      end
    end
    if (m % 2 == 1) return srt[m / 2];
    pair_sum = $signed(srt[m / 2 - 1]) + $signed(srt[m / 2]);
    return pair_sum[SAMPLE_WIDTH:1];
  endfunction

  // Works out the outputs caused by one accepted sample and advances the history.
  task automatic predict_filter(input logic [SAMPLE_WIDTH-1:0] value, input logic eos);
    logic signed [SAMPLE_WIDTH-1:0] keys[NUM_KEYS];
    int half, n, c, first, lo, hi;
    half = window_five_sel ? 2 : 1;
    n = series_hist.size();
    for (int i = 0; i < NUM_KEYS; i++) keys[i] = '0;
    for (int i = 0; i < n; i++) keys[i] = series_hist[i];
    keys[n] = value;
    c = n + 1;
    first = c - 1 - half;
    if (eos) begin
      // The last sample flushes every position still waiting for its window.
      for (int q = (first < 0) ? 0 : first; q <= c - 1; q++) begin
        lo = (q - half < 0) ? 0 : q - half;
        hi = (q + half > c - 1) ? c - 1 : q + half;
        pending_results.push_back('{med: window_median(keys, lo, hi), fin: (q == c - 1)});
      end
      series_hist.delete();
    end else begin
      if (first >= 0) begin
        lo = (first - half < 0) ? 0 : first - half;
        pending_results.push_back('{med: window_median(keys, lo, c - 1), fin: 1'b0});
      end
      series_hist.push_back(value);
      if (series_hist.size() > HISTORY_DEPTH) void'(series_hist.pop_front());
    end
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_idle_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    else if (roll < 90) return $urandom_range(1, 3);
    else if (roll < 97) return $urandom_range(4, 10);
    else return $urandom_range(20, 40);
  endfunction

  // Series lengths, weighted toward series longer than the window.
  function automatic int pick_series_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 1;
    else if (roll < 20) return 2;
    else if (roll < 30) return $urandom_range(3, 4);
    else if (roll < 85) return $urandom_range(5, 10);
    else return $urandom_range(11, 20);
  endfunction

  // Sample values: full range, extremes, values near zero, whole numbers and repeats.
  function automatic logic [SAMPLE_WIDTH-1:0] pick_sample(input logic [SAMPLE_WIDTH-1:0] prev);
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return SAMPLE_WIDTH'($signed($urandom_range(0, 8)) - 4);
      3: return prev;
      4: return SAMPLE_WIDTH'({16'($urandom_range(0, 65535)), 16'h0000});
      default: return SAMPLE_WIDTH'($urandom());
    endcase
  endfunction

  // Drives one sample transaction and records what it should produce.
  task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] value, input logic eos,
                             input logic typed, input logic [SAMPLE_WIDTH-1:0] t_med,
                             input logic t_fin);
    int gap;
    gap = steady_flow ? 0 : pick_idle_cycles();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= DATA_WIDTH'(value);
    s_tlast <= eos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_filter(value, eos);
    // A typed row states its own final result in place of the predicted one.
    if (typed) begin
      void'(pending_results.pop_back());
      pending_results.push_back('{med: t_med, fin: t_fin});
    end
    @(negedge clk);
  endtask

  // Selects the window once the block has gone quiet.
  task automatic write_window(input logic five);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= five;
    @(negedge clk);
    cfg_we <= 1'b0;
    window_five_sel = five;
  endtask

  // Stimulus: reset, directed table, then random phases.
  initial begin : stimulus
    int   sent, phase_left, series_left, phase_no;
    logic [SAMPLE_WIDTH-1:0] prev, value;
    stim_row_t row;
    sent = 0;
    series_left = 0;
    phase_no = 0;
    prev = '0;
    window_five_sel = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      row = directed_rows[r];
      if (row.kind == ROW_WINDOW) write_window(row.data[0]);
      else send_sample(row.data, row.eos, row.typed, row.t_med, row.t_fin);
    end

    // Phases may end inside a series, so window changes land mid-series too.
    while (sent < RANDOM_ITEMS) begin
      if (phase_no == 0) write_window(1'b0);
      else if (phase_no == 1) write_window(1'b1);
      else write_window($urandom_range(0, 1));
      steady_flow = ($urandom_range(0, 4) == 0);
      phase_left = $urandom_range(15, 40);
      while (phase_left > 0 && sent < RANDOM_ITEMS) begin
        if (series_left == 0) series_left = pick_series_length();
        value = pick_sample(prev);
        prev = value;
        send_sample(value, series_left == 1, 1'b0, '0, 1'b0);
        series_left--;
        phase_left--;
        sent++;
      end
      phase_no++;
    end
    if (series_left > 0) send_sample(pick_sample(prev), 1'b1, 1'b0, '0, 1'b0);
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("median_window_filter_unit_tb OK");
    end else begin
      $display("median_window_filter_unit_tb NOT OK");
    end
    $finish;
  end

  // Receiver back-pressure, updated at the falling edge.
  always @(negedge clk) begin
    if (steady_flow) begin
      m_tready <= 1'b1;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      m_tready <= ($urandom_range(0, 2) != 0);
      ready_hold = pick_idle_cycles();
    end
  end

  // Compare each result transaction against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h last %b", $time, m_tdata, m_tlast);
        fail_count++;
      end else begin
        want_result = pending_results.pop_front();
        if (m_tdata[SAMPLE_WIDTH-1:0] !== want_result.med) begin
          $display("%0t: median mismatch, expected %h, got %h",
                   $time, want_result.med, m_tdata[SAMPLE_WIDTH-1:0]);
          fail_count++;
        end
        if (m_tlast !== want_result.fin) begin
          $display("%0t: last mark mismatch, expected %b, got %b",
                   $time, want_result.fin, m_tlast);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("median_window_filter_unit_tb NOT OK");
      $finish;
    end
  end

endmodule
